// ----- rtl/core/regex_dot_star_matcher_defines.svh -----
// Assertion macros for the checker file of the matcher.
// No dependencies; the including file supplies clk and rst_n.
`ifndef REGEX_DOT_STAR_MATCHER_DEFINES_SVH
`define REGEX_DOT_STAR_MATCHER_DEFINES_SVH

// Property checked only while the block is out of reset.
`define RDSM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, including reset cycles.
`define RDSM_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rdsm_pkg.sv -----
// Shared types and constants for the dot-star regular expression matcher.
// No dependencies.
`default_nettype none

package rdsm_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] DOT_CHAR  = 8'h2E;

endpackage

`default_nettype wire

// ----- rtl/core/regex_dot_star_matcher.sv -----
// Dot-star regular expression matcher, top level.
// Depends on rdsm_pkg for the action codes and the special characters.
//
// The block takes one transaction per clock unless in_stall is high. Each one
// is captured in an input register and applied to the match state when it
// leaves that register; a finish transaction also puts its result in an output
// register. The row update for a text byte ripples through runs of starred
// elements across the pattern positions combinationally when the byte is
// applied.
// The input side stalls only while a finish waits behind an undelivered result.
`default_nettype none

module regex_dot_star_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire rdsm_pkg::action_t in_action,
  input  wire logic [7:0]       in_char_value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_matched,
  output logic                  out_pattern_fault
);
  import rdsm_pkg::*;

  localparam int ROW_W  = PATTERN_MAX + 1;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int ADDR_W = $clog2(PATTERN_MAX);

  logic              s1_valid_r, s1_valid_nxt;
  action_t           s1_action_r;
  logic [7:0]        s1_char_r;
  logic              s1_blocked, s1_fire, in_accept;

  logic [7:0]        pat_r [PATTERN_MAX];
  logic [LEN_W-1:0]  len_r, len_nxt, new_len;
  logic [ROW_W-1:0]  empty_r, empty_nxt, empty_app;
  logic [ROW_W-1:0]  live_r, live_nxt, text_row;
  logic              fault_r, fault_nxt;
  logic              last_star_r, last_star_nxt;
  logic              is_star, append_bad, append_ok, match_bit;

  logic              out_valid_r, out_valid_nxt;
  logic              out_matched_r, out_fault_r;

  assign s1_blocked = (s1_action_r == ACT_FINISH) && out_valid_r && out_stall;
  assign s1_fire    = s1_valid_r && !s1_blocked;
  assign in_stall   = s1_valid_r && s1_blocked;
  assign in_accept  = in_valid && !in_stall;

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_char_r   <= in_char_value;
    end
  end

  assign is_star    = (s1_char_r == STAR_CHAR);
  assign append_bad = (len_r == LEN_W'(PATTERN_MAX)) ||
                      (is_star && ((len_r == '0) || last_star_r));
  assign append_ok  = s1_fire && (s1_action_r == ACT_APPEND) && !append_bad;
  assign new_len    = len_r + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (append_ok) begin
      pat_r[len_r[ADDR_W-1:0]] <= s1_char_r;
    end
  end

  assign empty_app[0] = empty_r[0];
  assign text_row[0]  = 1'b0;

  for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_pos
    logic active;
    logic p_fits;
    assign active = (LEN_W'(j) <= len_r);
    assign p_fits = (pat_r[j-1] == DOT_CHAR) || (pat_r[j-1] == s1_char_r);
    if (j >= 2) begin : g_star
      logic e_fits;
      logic p_star;
      assign p_star = (pat_r[j-1] == STAR_CHAR);
      assign e_fits = (pat_r[j-2] == DOT_CHAR) || (pat_r[j-2] == s1_char_r);
      assign empty_app[j] = (LEN_W'(j) == new_len) ? (is_star && empty_r[j-2]) : empty_r[j];
      assign text_row[j]  = active && (p_star ? (text_row[j-2] || (e_fits && live_r[j]))
                                              : (p_fits && live_r[j-1]));
    end else begin : g_first
      assign empty_app[j] = (LEN_W'(j) == new_len) ? 1'b0 : empty_r[j];
      assign text_row[j]  = active && p_fits && live_r[j-1];
    end
  end

  always_comb begin
    match_bit = 1'b0;
    for (int j = 0; j <= PATTERN_MAX; j++) begin
      if (LEN_W'(j) == len_r) begin
        match_bit = live_r[j];
      end
    end
  end

  always_comb begin
    len_nxt       = len_r;
    empty_nxt     = empty_r;
    live_nxt      = live_r;
    fault_nxt     = fault_r;
    last_star_nxt = last_star_r;
    if (s1_fire) begin
      case (s1_action_r)
        ACT_CLEAR: begin
          len_nxt       = '0;
          empty_nxt     = ROW_W'(1);
          live_nxt      = ROW_W'(1);
          fault_nxt     = 1'b0;
          last_star_nxt = 1'b0;
        end
        ACT_APPEND: begin
          if (append_bad) begin
            fault_nxt = 1'b1;
          end else begin
            len_nxt       = new_len;
            empty_nxt     = empty_app;
            live_nxt      = empty_app;
            last_star_nxt = is_star;
          end
        end
        ACT_TEXT: begin
          live_nxt = text_row;
        end
        default: begin
          live_nxt = empty_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      empty_r     <= ROW_W'(1);
      live_r      <= ROW_W'(1);
      fault_r     <= 1'b0;
      last_star_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      empty_r     <= empty_nxt;
      live_r      <= live_nxt;
      fault_r     <= fault_nxt;
      last_star_r <= last_star_nxt;
    end
  end

  assign out_valid_nxt = (s1_fire && (s1_action_r == ACT_FINISH)) ? 1'b1 :
                         (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_action_r == ACT_FINISH)) begin
      out_matched_r <= !fault_r && match_bit;
      out_fault_r   <= fault_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_pattern_fault = out_fault_r;

endmodule

`default_nettype wire

// ----- rtl/core/rdsm_checker.sv -----
// Port-level checks for the dot-star matcher, bound to its top level.
// Depends on regex_dot_star_matcher_defines.svh for the assertion macros.
`default_nettype none
`include "regex_dot_star_matcher_defines.svh"

module rdsm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_matched,
  input wire logic out_pattern_fault
);

  `RDSM_CHECK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `RDSM_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_matched) && $stable(out_pattern_fault), "stalled result changed")
  `RDSM_CHECK(a_match_no_fault, out_valid |-> !(out_matched && out_pattern_fault), "match reported with a pattern fault")
  `RDSM_CHECK(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a blocked result")

endmodule

bind regex_dot_star_matcher rdsm_checker u_rdsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_matched       (out_matched),
  .out_pattern_fault (out_pattern_fault)
);

`default_nettype wire
